### design/tcch_pkg.sv
//------------------------------------------------------------------------------
// tcch_pkg
// Shared constants and a function for the compass heading pipeline.
//------------------------------------------------------------------------------
package tcch_pkg;

    localparam int ATAN_LEN = 24;

    localparam logic signed [31:0] ANG_PI      = 32'sd843314857;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [31:0] INV_GAIN    = 32'sd652032874;
    localparam logic [25:0]        DEG_SCALE   = 26'd60078979;
    localparam int                 DEG_SHIFT   = 48;

    // Arctangent of 2^-i in Q3.28 radians.
    function automatic logic signed [31:0] atan_entry(input int idx);
        logic signed [31:0] v;
        begin
            unique case (idx)
                0:  v = 32'sd210828714;
                1:  v = 32'sd124459457;
                2:  v = 32'sd65760959;
                3:  v = 32'sd33381290;
                4:  v = 32'sd16755422;
                5:  v = 32'sd8385879;
                6:  v = 32'sd4193963;
                7:  v = 32'sd2097109;
                8:  v = 32'sd1048571;
                9:  v = 32'sd524287;
                default: v = 32'sd1 <<< (28 - idx);
            endcase
            return v;
        end
    endfunction

endpackage

### design/tcch_rot_cell.sv
//------------------------------------------------------------------------------
// tcch_rot_cell
// One rotation CORDIC stage for sine and cosine; also carries the sidecar data.
//------------------------------------------------------------------------------
module tcch_rot_cell
    import tcch_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [31:0]       i_x,
    input  logic signed [31:0]       i_y,
    input  logic signed [31:0]       i_z,
    input  logic [SIDE_W-1:0]        i_side,
    output logic signed [31:0]       o_x,
    output logic signed [31:0]       o_y,
    output logic signed [31:0]       o_z,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [31:0] r_x, r_y, r_z;
    logic [SIDE_W-1:0]  r_side;
    logic signed [31:0] n_x, n_y, n_z;

    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - atan_entry(STAGE);
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + atan_entry(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_side = r_side;

endmodule

### design/tcch_vec_cell.sv
//------------------------------------------------------------------------------
// tcch_vec_cell
// One vectoring CORDIC stage for the arctangent.
//------------------------------------------------------------------------------
module tcch_vec_cell
    import tcch_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [48:0]       i_x,
    input  logic signed [48:0]       i_y,
    input  logic signed [31:0]       i_z,
    input  logic                     i_zero,
    output logic signed [48:0]       o_x,
    output logic signed [48:0]       o_y,
    output logic signed [31:0]       o_z,
    output logic                     o_zero
);

    logic signed [48:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic               r_zero;
    logic signed [48:0] n_x, n_y;
    logic signed [31:0] n_z;

    always_comb begin
        if (i_y >= 0) begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + atan_entry(STAGE);
        end else begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - atan_entry(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_zero <= i_zero;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_zero = r_zero;

endmodule

### design/tilt_compensated_compass_heading.sv
// Pipeline: one fold stage, CORDIC_STAGES rotation cells, one product stage, one
// half-plane fold stage, CORDIC_STAGES vectoring cells, two degree stages.
// Each chain's cell count is CORDIC_STAGES capped at ATAN_LEN.
// Throughput: one transaction per cycle; the whole pipeline advances unless the
// output register holds a result that is stalled.
// Reset: synchronous, active low; clears valid bits and sets r_mode to 1.
//------------------------------------------------------------------------------
// tilt_compensated_compass_heading
// Pipelined CORDIC chain turning a magnetometer vector and tilt into a heading.
//------------------------------------------------------------------------------
module tilt_compensated_compass_heading
    import tcch_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_mag_x,
    input  logic signed [15:0] i_mag_y,
    input  logic signed [15:0] i_mag_z,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [8:0]         o_heading_deg
);

    localparam int NS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int DEPTH = 2 * NS + 5;
    localparam int SIDE_W = 51;   // mx, my, mz, flip_r, flip_p, mode

    logic r_mode;
    logic [DEPTH-1:0] r_vld;
    logic en;

    // A stalled output stage halts the whole chain.
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_valid};
            end
        end
    end

    // Stage 0: quadrant fold of both angles.
    logic signed [31:0] r_zr, r_zp;
    logic [SIDE_W-1:0]  r_side0;
    logic signed [31:0] n_zr, n_zp;
    logic               n_fr, n_fp;

    always_comb begin
        n_zr = 32'(i_roll_angle) <<< 15;
        n_zp = 32'(i_pitch_angle) <<< 15;
        n_fr = 1'b0;
        n_fp = 1'b0;
        if (n_zr > ANG_HALF_PI) begin
            n_zr = n_zr - ANG_PI; n_fr = 1'b1;
        end else if (n_zr < -ANG_HALF_PI) begin
            n_zr = n_zr + ANG_PI; n_fr = 1'b1;
        end
        if (n_zp > ANG_HALF_PI) begin
            n_zp = n_zp - ANG_PI; n_fp = 1'b1;
        end else if (n_zp < -ANG_HALF_PI) begin
            n_zp = n_zp + ANG_PI; n_fp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zr    <= n_zr;
            r_zp    <= n_zp;
            r_side0 <= {i_mag_x, i_mag_y, i_mag_z, n_fr, n_fp, r_mode};
        end
    end

    // Rotation chains for roll and pitch.
    logic signed [31:0] rx [NS+1], ry [NS+1], rz [NS+1];
    logic signed [31:0] px [NS+1], py [NS+1], pz [NS+1];
    logic [SIDE_W-1:0]  sd [NS+1];
    logic [SIDE_W-1:0]  sd_unused [NS];

    assign rx[0] = INV_GAIN; assign ry[0] = '0; assign rz[0] = r_zr;
    assign px[0] = INV_GAIN; assign py[0] = '0; assign pz[0] = r_zp;
    assign sd[0] = r_side0;

    for (genvar g = 0; g < NS; g++) begin : g_rot
        tcch_rot_cell #(.STAGE(g), .SIDE_W(SIDE_W)) u_roll (
            .i_clk(i_clk), .i_en(en),
            .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]), .i_side(sd[g]),
            .o_x(rx[g+1]), .o_y(ry[g+1]), .o_z(rz[g+1]), .o_side(sd[g+1])
        );
        tcch_rot_cell #(.STAGE(g), .SIDE_W(SIDE_W)) u_pitch (
            .i_clk(i_clk), .i_en(en),
            .i_x(px[g]), .i_y(py[g]), .i_z(pz[g]), .i_side(sd[g]),
            .o_x(px[g+1]), .o_y(py[g+1]), .o_z(pz[g+1]), .o_side(sd_unused[g])
        );
    end

    // Product stage: four 16x32 products, then the sums.
    logic signed [15:0] s_mx, s_my, s_mz;
    logic               s_fr, s_fp, s_mode;
    logic signed [31:0] cr, sr, cp, sp;
    assign {s_mx, s_my, s_mz, s_fr, s_fp, s_mode} = sd[NS];
    assign cr = s_fr ? -rx[NS] : rx[NS];
    assign sr = s_fr ? -ry[NS] : ry[NS];
    assign cp = s_fp ? -px[NS] : px[NS];
    assign sp = s_fp ? -py[NS] : py[NS];

    logic signed [47:0] r_p0, r_p1, r_p2, r_p3;
    logic               r_md1;
    logic signed [15:0] r_my1, r_mz1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0  <= 48'(s_mx) * 48'(cr);
            r_p1  <= 48'(s_my) * 48'(sr);
            r_p2  <= 48'(s_mz) * 48'(cp);
            r_p3  <= 48'(s_my) * 48'(sp);
            r_md1 <= s_mode;
            r_my1 <= s_my;
            r_mz1 <= s_mz;
        end
    end

    logic signed [48:0] n_ay, n_ax;
    logic signed [48:0] r_vy, r_vx;
    logic signed [31:0] r_vz;
    logic               r_vzero;

    always_comb begin
        if (r_md1) begin
            n_ay = 49'(r_p0) - 49'(r_p1);
            n_ax = 49'(r_p2) + 49'(r_p3);
        end else begin
            n_ay = 49'(r_my1) <<< 30;
            n_ax = -(49'(r_mz1) <<< 30);
        end
    end

    // Half-plane fold into the vectoring chain.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vzero <= (n_ay == 0) && (n_ax == 0);
            if (n_ax < 0) begin
                r_vx <= -n_ax;
                r_vy <= -n_ay;
                r_vz <= (n_ay >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_vx <= n_ax;
                r_vy <= n_ay;
                r_vz <= '0;
            end
        end
    end

    logic signed [48:0] vx [NS+1], vy [NS+1];
    logic signed [31:0] vz [NS+1];
    logic               vzr [NS+1];

    assign vx[0] = r_vx; assign vy[0] = r_vy; assign vz[0] = r_vz;
    assign vzr[0] = r_vzero;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        tcch_vec_cell #(.STAGE(g)) u_vec (
            .i_clk(i_clk), .i_en(en),
            .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]), .i_zero(vzr[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]), .o_zero(vzr[g+1])
        );
    end

    // Degree conversion: magnitude times scale, then sign and wrap.
    logic [31:0] mag;
    logic        neg;
    assign neg = vz[NS] < 0;
    assign mag = neg ? 32'(-vz[NS]) : 32'(vz[NS]);

    logic [57:0] r_prod;
    logic        r_neg, r_zero2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= 58'(mag) * 58'(DEG_SCALE);
            r_neg   <= neg;
            r_zero2 <= vzr[NS];
        end
    end

    logic [9:0] q;
    logic [8:0] n_deg, r_deg;
    assign q = 10'(r_prod >> DEG_SHIFT);

    always_comb begin
        if (r_zero2 || (q == '0)) begin
            n_deg = '0;
        end else if (r_neg) begin
            n_deg = 9'(10'd360 - q);
        end else begin
            n_deg = q[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg <= n_deg;
        end
    end

    assign o_heading_deg = r_deg;

endmodule

### tb/tilt_compensated_compass_heading_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tilt_compensated_compass_heading_test
// Drives magnetometer and tilt samples with random gaps and output stalls,
// predicts each heading with a local fixed-point CORDIC model, and compares.
//------------------------------------------------------------------------------
module tilt_compensated_compass_heading_test;
    import tcch_pkg::*;

    localparam int STAGES = 16;
    localparam int DRAIN_CYCLES = 2 * STAGES + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint PI_Q28 = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint INV_K_Q30 = 64'sd652032874;
    localparam longint unsigned RAD_TO_DEG_Q20 = 64'd60078979;
    localparam logic MODE_LEVEL = 1'b0;
    localparam logic MODE_TILT = 1'b1;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } sample_t;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [15:0] i_mag_x, i_mag_y, i_mag_z, i_roll_angle, i_pitch_angle;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;
    logic o_valid;
    logic i_stall;
    logic [8:0] o_heading_deg;

    sample_t pending_samples[$];
    logic [8:0] expected_headings[$];
    logic heading_mode;
    int errors;
    int cycles;
    int send_gap;
    int stall_left;
    logic calm_send;
    logic calm_recv;

    tilt_compensated_compass_heading #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mag_x(i_mag_x), .i_mag_y(i_mag_y), .i_mag_z(i_mag_z),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_heading_deg(o_heading_deg)
    );

    function automatic longint atan_step(input int idx);
        longint t[0:15] = '{210828714, 124459457, 65760959, 33381290,
                            16755422, 8385879, 4193963, 2097109,
                            1048571, 524287, 262144, 131072,
                            65536, 32768, 16384, 8192};
        return t[idx];
    endfunction

    // Rotation CORDIC: Q2.13 angle in, cosine and sine in Q1.30 out.
    task automatic rotate_unit(input logic signed [15:0] ang, output longint c,
                               output longint s);
        longint z, x, y, dx, dy;
        logic flip;
        z = longint'(ang) * 32768;
        x = INV_K_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q28) begin
            z -= PI_Q28;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q28) begin
            z += PI_Q28;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vector_angle(input longint yy, input longint xx);
        longint z, x, y, dx, dy;
        z = 0;
        x = xx;
        y = yy;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q28 : -PI_Q28;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    task automatic predict_heading(input sample_t smp, input logic mode,
                                   output logic [8:0] deg);
        longint cr, sr, cp, sp, ay, ax, ang, d;
        longint unsigned mag;
        if (mode == MODE_TILT) begin
            rotate_unit(smp.roll, cr, sr);
            rotate_unit(smp.pitch, cp, sp);
            ay = longint'(smp.mx) * cr - longint'(smp.my) * sr;
            ax = longint'(smp.mz) * cp + longint'(smp.my) * sp;
        end else begin
            ay = longint'(smp.my) * 64'sd1073741824;
            ax = -longint'(smp.mz) * 64'sd1073741824;
        end
        if (ay == 0 && ax == 0) begin
            deg = 9'd0;
        end else begin
            ang = vector_angle(ay, ax);
            mag = (ang < 0) ? longint'(-ang) : ang;
            d = longint'((mag * RAD_TO_DEG_Q20) >> 48);
            if (ang < 0) d = -d;
            if (d < 0) d += 360;
            deg = d[8:0];
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sample driver: one transaction per queued sample, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                logic [8:0] deg;
                predict_heading({i_mag_x, i_mag_y, i_mag_z, i_roll_angle, i_pitch_angle},
                                heading_mode, deg);
                expected_headings.push_back(deg);
            end
            if ($urandom_range(0, 149) == 0) calm_send <= ~calm_send;
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    sample_t smp;
                    smp = pending_samples.pop_front();
                    i_mag_x <= smp.mx;
                    i_mag_y <= smp.my;
                    i_mag_z <= smp.mz;
                    i_roll_angle <= smp.roll;
                    i_pitch_angle <= smp.pitch;
                    i_valid <= 1'b1;
                    send_gap <= calm_send ? 0 : $urandom_range(0, 11);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random output stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if ($urandom_range(0, 149) == 0) calm_recv <= ~calm_recv;
            if (o_valid && !i_stall) begin
                int k;
                if (expected_headings.size() == 0) begin
                    report_mismatch($sformatf("unexpected heading %0d", o_heading_deg));
                end else begin
                    logic [8:0] want;
                    want = expected_headings.pop_front();
                    if (o_heading_deg !== want)
                        report_mismatch($sformatf("heading_deg got %0d want %0d",
                                                  o_heading_deg, want));
                end
                k = calm_recv ? 0 : $urandom_range(0, 11);
                stall_left <= k;
                i_stall <= (k > 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= (stall_left > 1);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_headings.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        heading_mode = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_mag(input logic wide);
        if (wide) return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic signed [15:0] pick_angle(input logic wide);
        if (wide) return 16'($urandom);
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    task automatic queue_random(input int n);
        sample_t smp;
        logic wide;
        for (int i = 0; i < n; i++) begin
            wide = ($urandom_range(0, 4) == 0);
            smp.mx = pick_mag(wide);
            smp.my = pick_mag(wide);
            smp.mz = pick_mag(wide);
            smp.roll = pick_angle(wide);
            smp.pitch = pick_angle(wide);
            // Occasionally zero components to hit axis and zero-vector cases.
            if ($urandom_range(0, 9) == 0) smp.mx = 0;
            if ($urandom_range(0, 9) == 0) smp.my = 0;
            if ($urandom_range(0, 9) == 0) smp.mz = 0;
            pending_samples.push_back(smp);
        end
    endtask

    task automatic queue_directed();
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
        pending_samples.push_back('{-16'sd16384, -16'sd16384, -16'sd16384,
                                    16'sd25736, -16'sd25736});
        pending_samples.push_back('{16'sd16384, 16'sd16384, 16'sd16384,
                                    -16'sd25736, 16'sd25736});
        pending_samples.push_back('{16'sd9000, -16'sd7000, -16'sd12000,
                                    16'sd20000, -16'sd20000});
        pending_samples.push_back('{-16'sd32768, 16'sd32767, -16'sd32768,
                                    16'sd32767, -16'sd32768});
        pending_samples.push_back('{16'sd32767, -16'sd32768, 16'sd32767,
                                    -16'sd32768, 16'sd32767});
        pending_samples.push_back('{16'sd100, 16'sd5, -16'sd3000, 16'sd12868, 16'sd12869});
        pending_samples.push_back('{-16'sd100, -16'sd5, 16'sd3000, -16'sd12869, -16'sd12868});
        pending_samples.push_back('{16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd1, 16'sd0, 16'sd1, 16'sd1, -16'sd1});
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        heading_mode = MODE_TILT;
        calm_send = 1'b0;
        calm_recv = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        i_mag_x = '0;
        i_mag_y = '0;
        i_mag_z = '0;
        i_roll_angle = '0;
        i_pitch_angle = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        wait_idle();
        write_mode(MODE_LEVEL);
        queue_directed();
        queue_random(400);
        wait_idle();
        write_mode(MODE_TILT);
        queue_random(700);
        wait_idle();
        write_mode(MODE_LEVEL);
        queue_random(300);
        wait_idle();
        write_mode(MODE_TILT);
        queue_random(370);
        wait_idle();

        if (errors == 0 && expected_headings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
